[src/dcfd_pkg.sv]
// Package for the DirectConnect flow detector: verdict and phase codes,
// match patterns and length thresholds. No dependencies.
`timescale 1ns / 1ps

package dcfd_pkg;

  typedef enum logic [1:0] {
    VERDICT_BUSY  = 2'd0,
    VERDICT_FOUND = 2'd1,
    VERDICT_NONE  = 2'd2,
    VERDICT_RSVD  = 2'd3
  } verdict_t;

  typedef enum logic [1:0] {
    PHASE_INIT  = 2'd0,
    PHASE_HUB   = 2'd1,
    PHASE_PEER  = 2'd2,
    PHASE_FOUND = 2'd3
  } phase_t;

  localparam logic [3:0] MAX_INSPECTIONS_RESET = 4'd10;

  localparam logic [47:0] PAT_LOCK = "$Lock ";
  localparam logic [63:0] PAT_NICK = "$MyNick ";
  localparam logic [71:0] PAT_ADC_MID = "SUP ADBAS";  // bytes 1..9 of the ADC forms
  localparam logic [31:0] PAT_SR   = "$SR ";

  localparam logic [7:0] CH_PIPE   = "|";
  localparam logic [7:0] CH_DOLLAR = "$";
  localparam logic [7:0] CH_LT     = "<";
  localparam logic [7:0] CH_RPAR   = ")";
  localparam logic [7:0] CH_H      = "H";
  localparam logic [7:0] CH_C      = "C";
  localparam logic [7:0] CH_ZERO   = "0";
  localparam logic [7:0] CH_E      = "E";

  localparam logic [15:0] LEN_TCP_MIN = 16'd6;   // tail marks need length above this
  localparam logic [15:0] LEN_NICK    = 16'd8;
  localparam logic [15:0] LEN_ADC     = 16'd11;
  localparam logic [15:0] LEN_UDP_MIN = 16'd58;

endpackage

[src/direct_connect_flow_detector.sv]
// Per-flow DirectConnect classifier: input register, verdict logic, result register.
// Depends on dcfd_pkg.
`timescale 1ns / 1ps

// Usage
//   Input channel (in_valid/in_ready): one packet summary per item, all for the
//   same flow. Result channel (out_valid/out_ready): one verdict per item, in
//   order: 0 in progress, 1 detected, 2 no match.
//   cfg_wr_en/cfg_wr_data write max_inspections; write only while no item is
//   in flight.
// Pipeline
//   An accepted item waits in the input register; then the verdict logic and
//   flow state update land in the result register. One item per cycle
//   sustained while out_ready stays high; the flow state is read and written in
//   the same cycle, so consecutive items need no bubble.
// Reset
//   Synchronous, active low. Both stages empty, flow phase and inspection count
//   zero, max_inspections back to 10.
// Stall
//   While out_ready is low the verdict holds; the input register still takes
//   one more item, then in_ready drops until the result is taken.
module direct_connect_flow_detector (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] in_head_high,
  input  logic [23:0] in_head_low,
  input  logic [23:0] in_tail_bytes,
  input  logic [15:0] in_payload_length,
  input  logic        in_from_responder,
  input  logic        in_is_udp,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_verdict,
  input  logic        cfg_wr_en,
  input  logic [3:0]  cfg_wr_data
);
  import dcfd_pkg::*;

  logic        s1_valid_r;
  logic [63:0] hh_r;
  logic [23:0] hl_r;
  logic [23:0] tl_r;
  logic [15:0] len_r;
  logic        resp_r;
  logic        udp_r;

  logic        out_valid_r;
  verdict_t    verdict_r, verdict_nxt;
  phase_t      phase_r, phase_nxt;
  logic [3:0]  count_r, count_nxt;
  logic [3:0]  max_insp_r;

  logic advance;
  logic accept;

  assign advance  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || advance;
  assign accept   = in_valid && in_ready;

  // Pattern compares on the registered item
  logic [7:0] head0, last, last2, last3;
  logic       m_lock, m_nick, m_adc, m_sr, tail_pd, tcp_long, udp_long;

  always_comb begin
    head0    = hh_r[63:56];
    last     = tl_r[7:0];
    last2    = tl_r[15:8];
    last3    = tl_r[23:16];
    tcp_long = len_r > LEN_TCP_MIN;
    udp_long = len_r > LEN_UDP_MIN;
    tail_pd  = (last2 == CH_PIPE) && (last == CH_DOLLAR);
    m_lock   = (hh_r[63:16] == PAT_LOCK);
    m_nick   = (hh_r == PAT_NICK) && (len_r >= LEN_NICK);
    m_adc    = (len_r >= LEN_ADC) && ((head0 == CH_H) || (head0 == CH_C))
               && ({hh_r[55:0], hl_r[23:8]} == PAT_ADC_MID)
               && ((hl_r[7:0] == CH_ZERO) || (hl_r[7:0] == CH_E));
    m_sr     = (hh_r[63:32] == PAT_SR);
  end

  // Verdict and flow state update
  logic       do_count;
  logic [4:0] cnt_inc;

  always_comb begin
    phase_nxt   = phase_r;
    count_nxt   = count_r;
    verdict_nxt = VERDICT_BUSY;
    do_count    = 1'b0;
    cnt_inc     = {1'b0, count_r} + 5'd1;

    if (len_r != 16'd0) begin
      if (!udp_r) begin
        unique case (phase_r)
          PHASE_INIT: begin
            if (tcp_long && (last == CH_PIPE) && m_lock) begin
              phase_nxt = PHASE_HUB;
              do_count  = 1'b1;
            end else if (tcp_long && (last == CH_PIPE) && m_nick) begin
              phase_nxt = PHASE_PEER;
              do_count  = 1'b1;
            end else if (m_adc) begin
              if (!resp_r) begin
                phase_nxt = PHASE_FOUND;
                do_count  = 1'b1;
              end else begin
                verdict_nxt = VERDICT_FOUND;
              end
            end else begin
              do_count = 1'b1;
            end
          end
          PHASE_HUB: begin
            if (m_adc || (tcp_long && ((head0 == CH_DOLLAR) || (head0 == CH_LT))
                          && tail_pd)) begin
              if (!resp_r) begin
                phase_nxt = PHASE_FOUND;
                do_count  = 1'b1;
              end else begin
                verdict_nxt = VERDICT_FOUND;
              end
            end else begin
              do_count = 1'b1;
            end
          end
          PHASE_PEER: begin
            if (tcp_long && (head0 == CH_DOLLAR) && tail_pd) begin
              if (!resp_r) begin
                phase_nxt = PHASE_FOUND;
                do_count  = 1'b1;
              end else begin
                verdict_nxt = VERDICT_FOUND;
              end
            end else begin
              do_count = 1'b1;
            end
          end
          PHASE_FOUND: begin
            if (!resp_r) begin
              do_count = 1'b1;
            end else begin
              verdict_nxt = VERDICT_FOUND;
            end
          end
          default: ;
        endcase
      end else begin
        // UDP: phase doubles as a miss count
        if (resp_r && (phase_r == PHASE_FOUND)) begin
          verdict_nxt = VERDICT_FOUND;
        end else if (udp_long) begin
          if (m_sr && (last3 == CH_RPAR) && tail_pd) begin
            if (!resp_r) begin
              phase_nxt = PHASE_FOUND;
              do_count  = 1'b1;
            end else begin
              verdict_nxt = VERDICT_FOUND;
            end
          end else begin
            phase_nxt = phase_t'(phase_r + 2'd1);
            if (phase_nxt == PHASE_FOUND) begin
              verdict_nxt = VERDICT_NONE;
            end else begin
              do_count = 1'b1;
            end
          end
        end else begin
          do_count = 1'b1;
        end
      end
    end

    // Saturating inspection count
    if (do_count) begin
      if (cnt_inc > {1'b0, max_insp_r}) begin
        count_nxt = max_insp_r;
      end else begin
        count_nxt = cnt_inc[3:0];
      end
      verdict_nxt = (count_nxt >= max_insp_r) ? VERDICT_NONE : VERDICT_BUSY;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      phase_r     <= PHASE_INIT;
      count_r     <= 4'd0;
      max_insp_r  <= MAX_INSPECTIONS_RESET;
    end else begin
      if (cfg_wr_en) begin
        max_insp_r <= cfg_wr_data;
      end
      if (accept) begin
        s1_valid_r <= 1'b1;
      end else if (advance) begin
        s1_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
        phase_r     <= phase_nxt;
        count_r     <= count_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers, no reset
  always_ff @(posedge clk) begin
    if (accept) begin
      hh_r   <= in_head_high;
      hl_r   <= in_head_low;
      tl_r   <= in_tail_bytes;
      len_r  <= in_payload_length;
      resp_r <= in_from_responder;
      udp_r  <= in_is_udp;
    end
    if (advance) begin
      verdict_r <= verdict_nxt;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_verdict = verdict_r;

endmodule

[src/dcfd_checker.sv]
// Port-level checker for the DirectConnect flow detector, bound to the top level.
// Depends on dcfd_pkg and direct_connect_flow_detector.
`timescale 1ns / 1ps

module dcfd_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] out_verdict
);
  import dcfd_pkg::*;

  // A stalled result keeps its verdict
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_verdict))
    else $error("result changed or dropped while stalled");

  a_verdict_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_verdict != VERDICT_RSVD)
    else $error("reserved verdict code on output");

  // Input side only backs up when both stages are full and the receiver stalls
  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without a stalled result");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("pipeline not empty after reset");

endmodule

bind direct_connect_flow_detector dcfd_checker u_dcfd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .out_verdict(out_verdict)
);

[dv/direct_connect_flow_detector_test.sv]
// Testbench for direct_connect_flow_detector: a directed table of packet summaries,
// then random flows, each verdict checked against the table's expected value or an in-bench flow predictor.
// Depends on dcfd_pkg and the detector RTL.
`timescale 1ns / 1ps

module direct_connect_flow_detector_test;
  import dcfd_pkg::*;

  typedef struct packed {
    logic [63:0] head_high;
    logic [23:0] head_low;
    logic [23:0] tail;
    logic [15:0] len;
    logic        resp;
    logic        udp;
  } packet_t;

  typedef struct packed {
    packet_t  pkt;
    logic     fixed;
    verdict_t want;
  } plan_row_t;

  localparam int N_PLAN        = 25;
  localparam int RANDOM_ROUNDS = 8;
  localparam int ROUND_ITEMS   = 50;

  localparam int TCP_TAIL_LEN = 6;   // trailing marks looked at above this length
  localparam int ADC_LEN      = 11;
  localparam int UDP_MIN_LEN  = 58;

  // handshake forms, left aligned in the 11-byte head
  localparam logic [87:0] LOCK_FORM = {"$Lock ", 40'h0};
  localparam logic [87:0] NICK_FORM = {"$MyNick ", 24'h0};
  localparam logic [87:0] SR_FORM   = {"$SR ", 56'h0};

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [63:0] in_head_high;
  logic [23:0] in_head_low;
  logic [23:0] in_tail_bytes;
  logic [15:0] in_payload_length;
  logic        in_from_responder;
  logic        in_is_udp;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  out_verdict;
  logic        cfg_wr_en;
  logic [3:0]  cfg_wr_data;

  // predicted flow state
  phase_t      flow_phase;
  logic [3:0]  inspect_count;
  logic [3:0]  inspect_limit;

  verdict_t    expected_verdicts[$];
  int          error_count;
  bit          steady;   // no idling on either side while set

  direct_connect_flow_detector uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_head_high      (in_head_high),
    .in_head_low       (in_head_low),
    .in_tail_bytes     (in_tail_bytes),
    .in_payload_length (in_payload_length),
    .in_from_responder (in_from_responder),
    .in_is_udp         (in_is_udp),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_verdict       (out_verdict),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #400_000;
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic logic [87:0] adc_form(input int k);
    case (k)
      0: return "HSUP ADBAS0";
      1: return "HSUP ADBASE";
      2: return "CSUP ADBAS0";
      default: return "CSUP ADBASE";
    endcase
  endfunction

  // bytes past the payload length never match
  function automatic logic head_has(input logic [87:0] head, input logic [87:0] form,
                                    input int n, input logic [15:0] len);
    for (int i = 0; i < n; i++)
      if (i >= len || head[87-8*i -: 8] != form[87-8*i -: 8]) return 1'b0;
    return 1'b1;
  endfunction

  function automatic logic any_adc_head(input logic [87:0] head, input logic [15:0] len);
    logic hit;
    hit = 1'b0;
    if (len >= ADC_LEN)
      for (int k = 0; k < 4; k++) hit = hit | head_has(head, adc_form(k), ADC_LEN, len);
    return hit;
  endfunction

  function automatic verdict_t bump_count();
    logic [4:0] nxt;
    nxt = inspect_count + 5'd1;
    if (nxt > inspect_limit) nxt = {1'b0, inspect_limit};
    inspect_count = nxt[3:0];
    if (inspect_count >= inspect_limit) return VERDICT_NONE;
    return VERDICT_BUSY;
  endfunction

  // an initiator match only arms detection; the responder reports it
  function automatic verdict_t on_match(input logic resp);
    if (!resp) begin
      flow_phase = PHASE_FOUND;
      return bump_count();
    end
    return VERDICT_FOUND;
  endfunction

  function automatic verdict_t classify_packet(input packet_t p);
    logic [87:0] head;
    logic [7:0]  last;
    logic [7:0]  last2;
    logic [7:0]  last3;
    logic [1:0]  step;
    logic        tail_ok;
    verdict_t    v;
    head  = {p.head_high, p.head_low};
    last  = p.tail[7:0];
    last2 = p.tail[15:8];
    last3 = p.tail[23:16];
    if (p.len == 0) return VERDICT_BUSY;
    if (!p.udp) begin
      tail_ok = p.len > TCP_TAIL_LEN && last2 == "|" && last == "$";
      case (flow_phase)
        PHASE_INIT: begin
          if (p.len > TCP_TAIL_LEN && last == "|" && head_has(head, LOCK_FORM, 6, p.len)) begin
            flow_phase = PHASE_HUB;
            v = bump_count();
          end else if (p.len > TCP_TAIL_LEN && last == "|"
                       && head_has(head, NICK_FORM, 8, p.len)) begin
            flow_phase = PHASE_PEER;
            v = bump_count();
          end else if (any_adc_head(head, p.len)) begin
            v = on_match(p.resp);
          end else begin
            v = bump_count();
          end
        end
        PHASE_HUB: begin
          if (any_adc_head(head, p.len)) v = on_match(p.resp);
          else if (tail_ok && (head[87:80] == "$" || head[87:80] == "<")) v = on_match(p.resp);
          else v = bump_count();
        end
        PHASE_PEER: begin
          if (tail_ok && head[87:80] == "$") v = on_match(p.resp);
          else v = bump_count();
        end
        default: v = on_match(p.resp);
      endcase
    end else if (p.resp && flow_phase == PHASE_FOUND) begin
      v = VERDICT_FOUND;
    end else if (p.len > UDP_MIN_LEN) begin
      if (head_has(head, SR_FORM, 4, p.len) && last3 == ")" && last2 == "|" && last == "$") begin
        v = on_match(p.resp);
      end else begin
        // miss counter lives in the phase; third miss ends the search
        step = flow_phase + 2'd1;
        flow_phase = phase_t'(step);
        if (flow_phase == PHASE_FOUND) v = VERDICT_NONE;
        else v = bump_count();
      end
    end else begin
      v = bump_count();
    end
    return v;
  endfunction

  function automatic packet_t make_packet();
    packet_t      p;
    int           pick;
    int           idx;
    logic [111:0] body;
    pick        = $urandom_range(0, 99);
    p.head_high = {$urandom, $urandom};
    p.head_low  = 24'($urandom);
    p.tail      = 24'($urandom);
    p.len       = 16'($urandom_range(1, 80));
    p.resp      = 1'($urandom_range(0, 1));
    p.udp       = 1'b0;
    if (pick < 12) begin
      p.head_high[63:16] = "$Lock ";
      p.tail[7:0] = "|";
      p.len = 16'($urandom_range(7, 40));
    end else if (pick < 22) begin
      p.head_high = "$MyNick ";
      p.tail[7:0] = "|";
      p.len = 16'($urandom_range(9, 40));
    end else if (pick < 38) begin
      {p.head_high, p.head_low} = adc_form($urandom_range(0, 3));
      p.len = 16'($urandom_range(11, 64));
    end else if (pick < 52) begin
      p.head_high[63:56] = $urandom_range(0, 1) ? "$" : "<";
      p.tail[15:0] = "|$";
      p.len = 16'($urandom_range(7, 40));
    end else if (pick < 68) begin
      p.udp = 1'b1;
      p.head_high[63:32] = "$SR ";
      p.tail = ")|$";
      p.len = 16'($urandom_range(59, 300));
    end else if (pick < 78) begin
      p.udp = 1'b1;
      p.len = 16'($urandom_range(40, 100));
    end else if (pick < 90) begin
      p.len = 16'($urandom);
    end
    // damage a share of the well-formed ones
    pick = $urandom_range(0, 99);
    if (pick < 10) begin
      body = {p.head_high, p.head_low, p.tail};
      idx = $urandom_range(0, 111);
      body[idx] = ~body[idx];
      {p.head_high, p.head_low, p.tail} = body;
    end else if (pick < 18) begin
      p.len = 16'($urandom_range(0, 12));
    end else if (pick < 21) begin
      p.len = 16'hFFFF;
    end
    if ($urandom_range(0, 19) == 0) p.udp = ~p.udp;
    return p;
  endfunction

  task automatic report_mismatch(input string what);
    error_count++;
    $display("[%0t] mismatch: %s", $time, what);
  endtask

  // called at a falling edge; returns at a falling edge
  task automatic send_packet(input packet_t p, input logic fixed, input verdict_t want);
    verdict_t v;
    in_valid          = 1'b1;
    in_head_high      = p.head_high;
    in_head_low       = p.head_low;
    in_tail_bytes     = p.tail;
    in_payload_length = p.len;
    in_from_responder = p.resp;
    in_is_udp         = p.udp;
    do @(posedge clk); while (!in_ready);
    v = classify_packet(p);
    expected_verdicts.push_back(fixed ? want : v);
    @(negedge clk);
    if (!steady && $urandom_range(0, 99) < 16) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
  endtask

  task automatic wait_drained();
    in_valid = 1'b0;
    while (expected_verdicts.size() != 0) @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_limit(input logic [3:0] value);
    wait_drained();
    cfg_wr_en   = 1'b1;
    cfg_wr_data = value;
    @(negedge clk);
    cfg_wr_en     = 1'b0;
    inspect_limit = value;
  endtask

  always @(negedge clk)
    out_ready <= steady || ($urandom_range(0, 99) >= 14);

  always @(posedge clk) begin : verdict_check
    verdict_t want_v;
    if (rst_n && out_valid && out_ready) begin
      if (expected_verdicts.size() == 0) begin
        report_mismatch("verdict with no item waiting");
      end else begin
        want_v = expected_verdicts.pop_front();
        if (out_verdict !== want_v)
          report_mismatch($sformatf("verdict %0d, predicted %0d", out_verdict, want_v));
      end
    end
  end

  initial begin
    plan_row_t  plan [N_PLAN];
    logic [3:0] round_limit;

    rst_n             = 1'b0;
    in_valid          = 1'b0;
    in_head_high      = '0;
    in_head_low       = '0;
    in_tail_bytes     = '0;
    in_payload_length = '0;
    in_from_responder = 1'b0;
    in_is_udp         = 1'b0;
    cfg_wr_en         = 1'b0;
    cfg_wr_data       = '0;
    steady            = 1'b0;
    error_count       = 0;
    flow_phase        = PHASE_INIT;
    inspect_count     = '0;
    inspect_limit     = MAX_INSPECTIONS_RESET;

    // pkt {head_high, head_low, tail, len, resp, udp}, fixed, want
    plan = '{
      // empty packet, every other field high: state untouched
      '{'{64'hFFFF_FFFF_FFFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF, 16'd0, 1'b1, 1'b1},
        1'b1, VERDICT_BUSY},
      // nick form cut by the length
      '{'{"$MyNick ", "abc", "ab|", 16'd7, 1'b0, 1'b0}, 1'b0, VERDICT_BUSY},
      '{'{64'hFFFF_FFFF_FFFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF, 16'hFFFF, 1'b1, 1'b0},
        1'b0, VERDICT_BUSY},
      '{'{{"$Lock ", "zz"}, "abc", "ab|", 16'd6, 1'b0, 1'b0}, 1'b0, VERDICT_BUSY},
      '{'{"HSUP ADB", "AS0", "xyz", 16'd10, 1'b1, 1'b0}, 1'b0, VERDICT_BUSY},
      // hub handshake
      '{'{{"$Lock ", "ab"}, "cde", "xy|", 16'd7, 1'b0, 1'b0}, 1'b0, VERDICT_BUSY},
      '{'{"HSUP ADB", "ASE", "xyz", 16'd11, 1'b1, 1'b0}, 1'b1, VERDICT_FOUND},
      '{'{{"<", 56'h0}, 24'h0, "a|$", 16'd7, 1'b0, 1'b0}, 1'b0, VERDICT_BUSY},
      '{'{64'h0, 24'h0, 24'h0, 16'd1, 1'b1, 1'b0}, 1'b1, VERDICT_FOUND},
      '{'{64'h0, 24'h0, 24'h0, 16'd1, 1'b1, 1'b1}, 1'b1, VERDICT_FOUND},
      // udp miss wraps the armed phase back to the start
      '{'{64'h0, 24'h0, 24'h0, 16'd59, 1'b0, 1'b1}, 1'b0, VERDICT_BUSY},
      // peer handshake
      '{'{"$MyNick ", "abc", "ab|", 16'd9, 1'b0, 1'b0}, 1'b0, VERDICT_BUSY},
      '{'{{"$", 56'h0}, 24'h0, "x|$", 16'd7, 1'b1, 1'b0}, 1'b1, VERDICT_FOUND},
      '{'{"CSUP ADB", "ASE", "x|$", 16'd11, 1'b1, 1'b0}, 1'b0, VERDICT_BUSY},
      '{'{{"$", 56'h0}, 24'h0, "x|$", 16'd7, 1'b0, 1'b0}, 1'b0, VERDICT_BUSY},
      // search reply at and just above the length threshold
      '{'{{"$SR ", 32'h0}, 24'h0, ")|$", 16'd58, 1'b0, 1'b1}, 1'b0, VERDICT_BUSY},
      '{'{{"$SR ", 32'h0}, 24'h0, ")|$", 16'd59, 1'b0, 1'b1}, 1'b0, VERDICT_BUSY},
      '{'{64'h0, 24'h0, 24'h0, 16'hFFFF, 1'b0, 1'b1}, 1'b0, VERDICT_BUSY},
      '{'{64'h0, 24'h0, 24'h0, 16'd60, 1'b0, 1'b1}, 1'b0, VERDICT_BUSY},
      '{'{64'h0, 24'h0, 24'h0, 16'd61, 1'b0, 1'b1}, 1'b0, VERDICT_BUSY},
      // third miss: no match without counting
      '{'{64'h0, 24'h0, 24'h0, 16'd62, 1'b0, 1'b1}, 1'b0, VERDICT_BUSY},
      '{'{64'h0, 24'h0, 24'h0, 16'd5, 1'b1, 1'b1}, 1'b1, VERDICT_FOUND},
      '{'{{"$SR ", 32'h0}, 24'h0, "(|$", 16'd100, 1'b0, 1'b1}, 1'b0, VERDICT_BUSY},
      '{'{"CSUP ADB", "AS0", 24'h0, 16'd11, 1'b1, 1'b0}, 1'b1, VERDICT_FOUND},
      '{'{"HSUP ADB", "AS0", 24'h0, 16'd11, 1'b0, 1'b0}, 1'b0, VERDICT_BUSY}
    };

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    for (int i = 0; i < N_PLAN; i++)
      send_packet(plan[i].pkt, plan[i].fixed, plan[i].want);

    for (int r = 0; r < RANDOM_ROUNDS; r++) begin
      case (r)
        0: round_limit = 4'd0;
        1: round_limit = 4'd15;
        2: round_limit = 4'd1;
        4: round_limit = 4'd5;
        6: round_limit = 4'($urandom_range(1, 14));
        7: round_limit = 4'd3;
        default: round_limit = 4'd15;
      endcase
      set_limit(round_limit);
      steady = (r == 3);
      for (int n = 0; n < ROUND_ITEMS; n++) begin
        if (r == 1 && n == ROUND_ITEMS / 2) wait_drained();
        send_packet(make_packet(), 1'b0, VERDICT_BUSY);
      end
    end
    steady = 1'b0;

    wait_drained();
    repeat (8) @(posedge clk);
    if (error_count == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
